// ----- rtl/core/simcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package simcm_pkg;

  // Field widths of the input and result items.
  localparam int unsigned EntryW     = 32;
  localparam int unsigned ClusterW   = 22;
  localparam int unsigned StartW     = 32;
  localparam int unsigned EndSectorW = 49;
  localparam int unsigned FileW      = 48;
  localparam int unsigned HostW      = 54;
  localparam int unsigned CountW     = 29;
  localparam int unsigned ExtentW    = 63;

  // Register index port and data port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 49;

  // One sector is 512 bytes, so a sector count becomes bytes by a shift.
  localparam int unsigned SectorShift = 9;

  // An end sector is below 2^49, so its byte address fits in 58 bits.
  localparam int unsigned EndByteW = EndSectorW + SectorShift;

  // Largest mapped cluster count that the result can show.
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Register indexes.
  localparam logic [CfgIdxW-1:0] REG_EXT_MODE      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CLUSTER_SECT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DATA_START    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DATA_END      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FILE_SIZE     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BASE_EXTENT   = 3'd5;

  // Configuration register file contents.
  typedef struct packed {
    logic                  ext_mode;
    logic [ClusterW-1:0]   cluster_sectors;
    logic [StartW-1:0]     area_base;
    logic [EndSectorW-1:0] area_limit;
    logic [FileW-1:0]      file_size;
    logic [FileW-1:0]      base_extent;
  } cfg_t;

  // Reload of the furthest extent when the base extent is written.
  typedef struct packed {
    logic             load;
    logic [FileW-1:0] value;
  } base_load_t;

  // Classified entry handed from the mapping pipeline to the accumulator.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic                mapped;
    logic [HostW-1:0]    host;
    logic [EndByteW-1:0] end_bytes;
    logic                end_over_file;
  } map_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/simcm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface simcm_in_if
  import simcm_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [EntryW-1:0]  bat_entry;
  logic               last_entry;

  modport source (output valid, output bat_entry, output last_entry, input ready);
  modport sink   (input valid, input bat_entry, input last_entry, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/simcm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface simcm_out_if
  import simcm_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               mapped;
  logic [HostW-1:0]   host_sector;
  logic [CountW-1:0]  mapped_count;
  logic [ExtentW-1:0] extent_bytes;
  logic               truncated;
  logic               final_res;

  modport source (output valid, output mapped, output host_sector, output mapped_count,
                  output extent_bytes, output truncated, output final_res, input ready);
  modport sink   (input valid, input mapped, input host_sector, input mapped_count,
                  input extent_bytes, input truncated, input final_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/simcm_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module simcm_cfg_regs
  import simcm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                     cfg,
  output base_load_t               base_load
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_EXT_MODE:     cfg_nxt.ext_mode        = cfg_wdata[0];
        REG_CLUSTER_SECT: cfg_nxt.cluster_sectors = cfg_wdata[ClusterW-1:0];
        REG_DATA_START:   cfg_nxt.area_base       = cfg_wdata[StartW-1:0];
        REG_DATA_END:     cfg_nxt.area_limit      = cfg_wdata[EndSectorW-1:0];
        REG_FILE_SIZE:    cfg_nxt.file_size       = cfg_wdata[FileW-1:0];
        REG_BASE_EXTENT:  cfg_nxt.base_extent     = cfg_wdata[FileW-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ext_mode        <= 1'b0;
      cfg_r.cluster_sectors <= ClusterW'(1);
      cfg_r.area_base       <= '0;
      cfg_r.area_limit      <= '0;
      cfg_r.file_size       <= '0;
      cfg_r.base_extent     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  // A base extent write also restarts the furthest extent.
  assign base_load.load  = cfg_we && (cfg_idx == REG_BASE_EXTENT);
  assign base_load.value = cfg_wdata[FileW-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/simcm_map_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

module simcm_map_pipe
  import simcm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  simcm_in_if.sink   in_ch,
  input  wire cfg_t  cfg,
  input  wire logic  acc_ready,
  output map_res_t   res
);

  // Stage 1: input register.
  logic              v1_r;
  logic [EntryW-1:0] entry_r;
  logic              last1_r;

  // Stage 2: scaled host sector.
  logic              v2_r;
  logic [HostW-1:0]  host2_r;
  logic              nz2_r;
  logic              last2_r;

  // Stage 3: classified entry.
  map_res_t          res_r;

  logic rdy1;
  logic rdy2;
  logic rdy3;

  logic [ClusterW-1:0] mult;
  logic [HostW-1:0]    host_nxt;
  logic [HostW:0]      sum;
  logic                mapped_nxt;
  logic [EndByteW-1:0] end_bytes_nxt;

  // Each stage moves on when the one after it is empty or moving on too.
  assign rdy3        = !res_r.valid || acc_ready;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  // Scale the entry by the cluster size in extended mode.
  assign mult     = cfg.ext_mode ? cfg.cluster_sectors : ClusterW'(1);
  assign host_nxt = HostW'(entry_r) * HostW'(mult);

  // Bounds check of a nonzero entry's cluster against the data area, and the end byte of the cluster.
  assign sum = {1'b0, host2_r} + (HostW+1)'(cfg.cluster_sectors);
  assign mapped_nxt = nz2_r && (host2_r >= HostW'(cfg.area_base)) &&
                      (sum <= (HostW+1)'(cfg.area_limit));
  assign end_bytes_nxt = {sum[EndSectorW-1:0], {SectorShift{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_ch.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        res_r.valid <= v2_r;
      end
      // Payload registers load on each transfer between stages.
      if (rdy1 && in_ch.valid) begin
        entry_r <= in_ch.bat_entry;
        last1_r <= in_ch.last_entry;
      end
      if (rdy2 && v1_r) begin
        host2_r <= host_nxt;
        nz2_r   <= (entry_r != '0);
        last2_r <= last1_r;
      end
      if (rdy3 && v2_r) begin
        res_r.last          <= last2_r;
        res_r.mapped        <= mapped_nxt;
        res_r.host          <= mapped_nxt ? host2_r : '0;
        res_r.end_bytes     <= end_bytes_nxt;
        res_r.end_over_file <= end_bytes_nxt > EndByteW'(cfg.file_size);
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- rtl/core/simcm_accum.sv -----
`timescale 1ns / 1ps
`default_nettype none

module simcm_accum
  import simcm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire base_load_t base_load,
  input  wire map_res_t   res,
  output logic            acc_ready,
  simcm_out_if.source     out_ch
);

  logic [CountW-1:0]   count_r;
  logic [CountW-1:0]   count_nxt;
  logic [EndByteW-1:0] furthest_r;
  logic [EndByteW-1:0] furthest_nxt;

  logic                out_valid_r;
  logic                mapped_r;
  logic [HostW-1:0]    host_r;
  logic [CountW-1:0]   out_count_r;
  logic [EndByteW-1:0] extent_r;
  logic                trunc_r;
  logic                final_r;

  logic                grow;
  logic                over_file;
  logic                clamp;
  logic [EndByteW-1:0] extent_nxt;
  logic                trunc_nxt;

  // The result register takes a new entry when it is empty or being read.
  assign acc_ready = !out_valid_r || out_ch.ready;

  // Running count and furthest extent including this entry.
  assign count_nxt = (res.mapped && (count_r != CountMax)) ? count_r + CountW'(1) : count_r;
  assign grow         = res.mapped && (res.end_bytes > furthest_r);
  assign furthest_nxt = grow ? res.end_bytes : furthest_r;

  // Clamp to the file size on the last entry of a table.
  assign over_file  = (furthest_r > EndByteW'(cfg.file_size)) ||
                      (res.mapped && res.end_over_file);
  assign clamp      = res.last && over_file;
  assign extent_nxt = clamp ? EndByteW'(cfg.file_size) : furthest_nxt;
  assign trunc_nxt  = clamp && (res.mapped || (count_r != '0));

  // Walk state, restarted after the last entry; a base extent write reloads only the furthest extent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      furthest_r <= '0;
    end else if (base_load.load) begin
      furthest_r <= EndByteW'(base_load.value);
    end else if (acc_ready && res.valid) begin
      if (res.last) begin
        count_r    <= '0;
        furthest_r <= EndByteW'(cfg.base_extent);
      end else begin
        count_r    <= count_nxt;
        furthest_r <= furthest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_ready && res.valid) begin
      mapped_r    <= res.mapped;
      host_r      <= res.host;
      out_count_r <= count_nxt;
      extent_r    <= extent_nxt;
      trunc_r     <= trunc_nxt;
      final_r     <= res.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mapped       = mapped_r;
  assign out_ch.host_sector  = host_r;
  assign out_ch.mapped_count = out_count_r;
  assign out_ch.extent_bytes = ExtentW'(extent_r);
  assign out_ch.truncated    = trunc_r;
  assign out_ch.final_res    = final_r;

endmodule

`default_nettype wire

// ----- rtl/core/sparse_image_cluster_mapper_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Transfer when        Payload
// in_ch     in   valid && ready       bat_entry[31:0], last_entry
// out_ch    out  valid && ready       mapped, host_sector[53:0], mapped_count[28:0],
//                                     extent_bytes[62:0], truncated, final_res
// cfg_*     in   cfg_we               cfg_idx[2:0], cfg_wdata[48:0]
//
// One table entry is taken per cycle unless a stalled result backs up the pipeline.
// The path runs input register, multiplier, bounds check, then the result register,
// where the mapped count and furthest extent are updated as it loads, bar a base extent write.
// Reset is synchronous; it empties the pipeline and loads the register reset values.
// A stalled result stops the full stages in an unbroken run behind it; a stage with an empty one ahead keeps moving.

module sparse_image_cluster_mapper_core
  import simcm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  simcm_in_if.sink                 in_ch,
  simcm_out_if.source              out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t       cfg;
  base_load_t base_load;
  map_res_t   res;
  logic       acc_ready;

  // Configuration registers.
  simcm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .base_load (base_load)
  );

  // Scaling and bounds check.
  simcm_map_pipe u_map_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .acc_ready (acc_ready),
    .res       (res)
  );

  // Count, extent and result register.
  simcm_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .base_load (base_load),
    .res       (res),
    .acc_ready (acc_ready),
    .out_ch    (out_ch)
  );

  // Truncation is only ever reported on the closing result.
  a_trunc_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.truncated) |-> out_ch.final_res)
    else $error("truncation flagged on a result that is not final");

  // An unmapped cluster carries no host sector.
  a_unmapped_host_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.mapped) |-> (out_ch.host_sector == '0))
    else $error("unmapped cluster shows a host sector");

  // A mapped cluster is always included in the count.
  a_mapped_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.mapped) |-> (out_ch.mapped_count != '0))
    else $error("mapped cluster with a zero count");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import simcm_pkg::*;

  // Pipeline depth of the block, from input transfer to result.
  localparam int unsigned PIPE_DEPTH     = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1030;
  localparam int unsigned CALM_ITEMS     = 150;
  localparam int unsigned CLUSTER_MAX    = 4186127;

  localparam logic [63:0] START_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] END_MAX   = 64'h0001_FFFF_FFFF_FFFF;
  localparam logic [63:0] BYTES_MAX = 64'h0000_FFFF_FFFF_FFFF;

  // Register indexes that the block has no register behind.
  localparam logic [CfgIdxW-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE7 = 3'd7;

  typedef struct packed {
    logic               mapped;
    logic [HostW-1:0]   host;
    logic [CountW-1:0]  count;
    logic [ExtentW-1:0] extent;
    logic               trunc;
    logic               closes_walk;
  } cluster_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CfgIdxW-1:0] idx;
    logic [63:0]      value;
    logic             last;
    cluster_result_t  want;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  simcm_in_if  in_ch ();
  simcm_out_if out_ch ();

  sparse_image_cluster_mapper_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the register file and of the table walk state.
  cfg_t               reg_mirror;
  logic [29:0]        walk_total;
  logic [ExtentW-1:0] walk_extent;

  cluster_result_t pending_results[$];
  directed_row_t   plan[$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned gap_odds     = 4;
  bit          calm         = 1'b0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Classify one table entry and advance the walk, as the block should.
  function automatic cluster_result_t map_entry(input logic [EntryW-1:0] entry,
                                                input logic last);
    cluster_result_t r;
    logic [63:0] scale;
    logic [63:0] host;
    logic [63:0] span_end;
    logic [63:0] end_bytes;
    logic        hit;
    scale    = reg_mirror.ext_mode ? 64'(reg_mirror.cluster_sectors) : 64'd1;
    host     = 64'(entry) * scale;
    span_end = host + 64'(reg_mirror.cluster_sectors);
    hit      = (entry != '0) && (host >= 64'(reg_mirror.area_base)) &&
               (span_end <= 64'(reg_mirror.area_limit));
    if (hit) begin
      end_bytes = span_end << SectorShift;
      if (walk_total < 30'(CountMax)) walk_total++;
      if (end_bytes > 64'(walk_extent)) walk_extent = end_bytes[ExtentW-1:0];
    end
    r.mapped = hit;
    r.host   = hit ? host[HostW-1:0] : '0;
    r.count  = walk_total[CountW-1:0];
    r.extent = walk_extent;
    r.trunc  = 1'b0;
    // The last entry reports the extent clamped to what the file holds.
    if (last && (walk_extent > ExtentW'(reg_mirror.file_size))) begin
      r.trunc  = (walk_total != '0);
      r.extent = ExtentW'(reg_mirror.file_size);
    end
    r.closes_walk = last;
    if (last) begin
      walk_total  = '0;
      walk_extent = ExtentW'(reg_mirror.base_extent);
    end
    return r;
  endfunction

  function automatic directed_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                            input logic [63:0] value);
    directed_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  function automatic directed_row_t item_row(input logic [63:0] entry, input logic last);
    directed_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.value = entry;
    r.last  = last;
    return r;
  endfunction

  function automatic directed_row_t known_row(input logic [63:0] entry, input logic last,
                                              input cluster_result_t want);
    directed_row_t r;
    r       = item_row(entry, last);
    r.kind  = ROW_KNOWN;
    r.want  = want;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  // Register write; the mirror follows at once since the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[CfgDataW-1:0];
    case (idx)
      REG_EXT_MODE:     reg_mirror.ext_mode        = value[0];
      REG_CLUSTER_SECT: reg_mirror.cluster_sectors = value[ClusterW-1:0];
      REG_DATA_START:   reg_mirror.area_base       = value[StartW-1:0];
      REG_DATA_END:     reg_mirror.area_limit      = value[EndSectorW-1:0];
      REG_FILE_SIZE:    reg_mirror.file_size       = value[FileW-1:0];
      REG_BASE_EXTENT: begin
        reg_mirror.base_extent = value[FileW-1:0];
        walk_extent            = ExtentW'(value[FileW-1:0]);
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one entry, with an optional gap first, and hold it until the transfer.
  task automatic send_entry(input logic [EntryW-1:0] entry, input logic last,
                            input logic known, input cluster_result_t want);
    cluster_result_t predicted;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.bat_entry  <= entry;
    in_ch.last_entry <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = map_entry(entry, last);
    pending_results.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  // Stop offering entries and wait until the block has nothing in flight.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // Result side: stall in random bursts, never once the run has gone calm.
  initial begin
    out_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    cluster_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("mapped", out_ch.mapped, want.mapped);
        check_field("host_sector", out_ch.host_sector, want.host);
        check_field("mapped_count", out_ch.mapped_count, want.count);
        check_field("extent_bytes", out_ch.extent_bytes, want.extent);
        check_field("truncated", out_ch.truncated, want.trunc);
        check_field("final_res", out_ch.final_res, want.closes_walk);
      end
      results_seen++;
    end
  end

  // Watchdog: the run ends if no transfer happens for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // Main stimulus: reset, directed table, then random phases.
  initial begin : stimulus
    int unsigned items_sent;
    int unsigned table_len;
    int unsigned span;
    bit          prev_item;
    logic        last;
    logic [63:0] ext_bit;
    logic [63:0] cs;
    logic [63:0] scale;
    logic [63:0] start;
    logic [63:0] area_end;
    logic [63:0] file;
    logic [63:0] base;
    logic [63:0] first_entry;
    logic [63:0] e;

    in_ch.valid      <= 1'b0;
    in_ch.bat_entry  <= '0;
    in_ch.last_entry <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_wdata        <= '0;
    rst_n            <= 1'b0;

    reg_mirror                 = '0;
    reg_mirror.cluster_sectors = ClusterW'(1);
    walk_total                 = '0;
    walk_extent                = '0;
    items_sent                 = 0;
    prev_item                  = 1'b0;
    span                       = 1;
    first_entry                = 64'd1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    plan = '{
      // Reset values leave the data area empty, so nothing maps.
      known_row(64'd0, 1'b0, '0),
      known_row(START_MAX, 1'b1, '{1'b0, 54'd0, 29'd0, 63'd0, 1'b0, 1'b1}),
      // Extended mode, eight sectors per cluster, small data area.
      reg_row(REG_EXT_MODE, 64'd1),
      reg_row(REG_CLUSTER_SECT, 64'd8),
      reg_row(REG_DATA_START, 64'd16),
      reg_row(REG_DATA_END, 64'd1024),
      reg_row(REG_FILE_SIZE, 64'd4096),
      reg_row(REG_BASE_EXTENT, 64'd0),
      known_row(64'd0, 1'b0, '0),
      item_row(64'd1, 1'b0),
      item_row(64'd2, 1'b0),
      item_row(64'd127, 1'b0),
      item_row(64'd128, 1'b0),
      item_row(START_MAX, 1'b1),
      // Extended mode off, a large cluster size, the other registers at their top values.
      reg_row(REG_EXT_MODE, 64'd0),
      reg_row(REG_CLUSTER_SECT, 64'(CLUSTER_MAX)),
      reg_row(REG_DATA_START, START_MAX),
      reg_row(REG_DATA_END, END_MAX),
      reg_row(REG_FILE_SIZE, BYTES_MAX),
      reg_row(REG_BASE_EXTENT, BYTES_MAX),
      item_row(START_MAX, 1'b0),
      known_row(64'hFFFF_FFFE, 1'b1, '{1'b0, 54'd0, 29'd1, 63'(BYTES_MAX), 1'b0, 1'b1}),
      // Widest host sector, and a file too short for the mapped cluster.
      reg_row(REG_EXT_MODE, 64'd1),
      reg_row(REG_DATA_START, 64'd0),
      reg_row(REG_FILE_SIZE, 64'd0),
      reg_row(REG_BASE_EXTENT, 64'd0),
      item_row(START_MAX, 1'b0),
      item_row(64'd1, 1'b0),
      known_row(64'd0, 1'b1, '{1'b0, 54'd0, 29'd1, 63'd0, 1'b1, 1'b1}),
      // Zero cluster size: every nonzero entry lands on sector 0.
      reg_row(REG_CLUSTER_SECT, 64'd0),
      reg_row(REG_DATA_END, 64'd0),
      item_row(64'd5, 1'b0),
      item_row(64'd0, 1'b0),
      // Writes to indexes with no register behind them must change nothing.
      reg_row(REG_SPARE6, END_MAX),
      reg_row(REG_SPARE7, END_MAX),
      item_row(64'h8000_0000, 1'b1),
      // Entries taken as sectors, at both edges of the data area.
      reg_row(REG_EXT_MODE, 64'd0),
      reg_row(REG_DATA_START, 64'd10),
      reg_row(REG_DATA_END, 64'd100),
      reg_row(REG_FILE_SIZE, 64'd1000),
      item_row(64'd9, 1'b0),
      item_row(64'd10, 1'b0),
      item_row(64'd100, 1'b0),
      item_row(64'd101, 1'b1)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (prev_item) settle();
        write_reg(plan[i].idx, plan[i].value);
        prev_item = 1'b0;
      end else begin
        send_entry(plan[i].value[EntryW-1:0], plan[i].last,
                   plan[i].kind == ROW_KNOWN, plan[i].want);
        prev_item = 1'b1;
      end
    end

    // Random phases: a fresh setting, then whole tables with random content.
    while (items_sent < RANDOM_ITEMS) begin
      settle();

      ext_bit = 64'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0:       cs = 64'd0;
        1:       cs = 64'(CLUSTER_MAX);
        2, 3:    cs = 64'($urandom_range(1, CLUSTER_MAX));
        default: cs = 64'($urandom_range(1, 64));
      endcase
      scale = (ext_bit != 0) ? cs : 64'd1;
      span  = $urandom_range(1, 3000);
      case ($urandom_range(0, 7))
        0:       start = {32'd0, $urandom};
        1:       start = 64'd0;
        default: start = scale * $urandom_range(0, 6);
      endcase
      case ($urandom_range(0, 7))
        0:       area_end = {$urandom, $urandom} & END_MAX;
        1:       area_end = 64'd0;
        2:       area_end = END_MAX;
        default: area_end = start + scale * span + cs + $urandom_range(0, 2);
      endcase
      case ($urandom_range(0, 7))
        0:       file = {$urandom, $urandom} & BYTES_MAX;
        1:       file = 64'd0;
        2:       file = BYTES_MAX;
        default: file = ((start + scale * $urandom_range(0, span) + cs) << SectorShift)
                        & BYTES_MAX;
      endcase
      case ($urandom_range(0, 5))
        0:       base = {$urandom, $urandom} & BYTES_MAX;
        1:       base = BYTES_MAX;
        2:       base = 64'($urandom_range(0, 65535));
        default: base = 64'd0;
      endcase
      first_entry = (scale == 0) ? 64'd1 : start / scale;

      write_reg(REG_EXT_MODE, ext_bit);
      write_reg(REG_CLUSTER_SECT, cs);
      write_reg(REG_DATA_START, start);
      write_reg(REG_DATA_END, area_end);
      write_reg(REG_FILE_SIZE, file);
      write_reg(REG_BASE_EXTENT, base);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE6 : REG_SPARE7, {$urandom, $urandom});
      end

      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        default: gap_odds = 10;
      endcase

      // A few tables per phase; now and then one is cut short by an early last.
      repeat ($urandom_range(1, 4)) begin
        table_len = $urandom_range(1, 48);
        for (int unsigned j = 0; j < table_len && items_sent < RANDOM_ITEMS; j++) begin
          case ($urandom_range(0, 9))
            0:       e = {32'd0, $urandom};
            1:       e = 64'd0;
            2:       e = START_MAX;
            default: e = first_entry + $urandom_range(0, span + 3) - 1;
          endcase
          last = (j == table_len - 1) || ($urandom_range(0, 19) == 0);
          send_entry(e[EntryW-1:0], last, 1'b0, '0);
          items_sent++;
          if (items_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
        end
      end
    end

    // Drain and let the pipeline run empty before the verdict.
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH * 4) @(negedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/simcm_pkg.sv
rtl/core/simcm_in_if.sv
rtl/core/simcm_out_if.sv
rtl/core/simcm_cfg_regs.sv
rtl/core/simcm_map_pipe.sv
rtl/core/simcm_accum.sv
rtl/core/sparse_image_cluster_mapper_core.sv
tb/tb_top.sv
